[rtl/itoa_pkg.sv]
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the integer-to-ascii formatter files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CountW  = 31;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDig  = 16;
  localparam int unsigned DigIdxW = 4;

  typedef enum logic [OpW-1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_HEX,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // reciprocal of ten, scaled by 2^35
  localparam logic [31:0]       Recip10   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipSh   = 35;
  localparam logic [CharW-1:0]  ChMinus   = 8'h2D;
  localparam logic [CharW-1:0]  ChZero    = 8'h30;
  localparam logic [CharW-1:0]  ChLowerA  = 8'h57;  // 'a' - 10
  localparam logic [CharW-1:0]  ChUpperA  = 8'h37;  // 'A' - 10
  localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};
  localparam logic [DigIdxW-1:0] LastIdx  = 4'd15;

  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                  input logic             upper);
    logic [CharW-1:0] base;
    if (d < 4'd10) begin
      base = ChZero;
    end else if (upper) begin
      base = ChUpperA;
    end else begin
      base = ChLowerA;
    end
    return base + {4'd0, d};
  endfunction

endpackage

`default_nettype wire

[rtl/itoa_if.sv]
// ----------------------------------------------------------------------------
// itoa channel interfaces
// Valid/ready channels for the formatter input and its character stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface itoa_in_if;
  logic                           valid;
  logic                           ready;
  logic [itoa_pkg::OpW-1:0]       op;
  logic [itoa_pkg::ValueW-1:0]    value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface itoa_out_if;
  logic                           valid;
  logic                           ready;
  logic [itoa_pkg::CharW-1:0]     char_code;
  logic                           last_char;
  logic [itoa_pkg::CountW-1:0]    total_printed;

  modport source (output valid, output char_code, output last_char,
                  output total_printed, input ready);
  modport sink   (input valid, input char_code, input last_char,
                  input total_printed, output ready);
endinterface

`default_nettype wire

[rtl/integer_to_ascii_formatter_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one integer as ascii characters, most significant digit first.
// ----------------------------------------------------------------------------
// One number is taken when the unit is idle. Digits are first produced least
// significant first into a 16-entry digit buffer, then sent out in reverse,
// one character per cycle while the sink is ready. Decimal digits come from a
// single shared reciprocal multiplier: each digit takes a multiply step, then
// a remainder step; a negative signed number is sent with a leading minus. Hex
// digits are shifted off at one per cycle. Input ready is high only while the
// unit is idle. total_printed counts every character sent since reset and
// saturates at its maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  itoa_in_if.sink    in_i,
  itoa_out_if.source out_o
);

  itoa_pkg::state_e state_q, state_d;

  logic [itoa_pkg::ValueW-1:0]  work_q, work_d;
  logic [63:0]                  prod_q;
  logic [itoa_pkg::DigIdxW-1:0] nd_q, nd_d;
  logic [itoa_pkg::DigIdxW-1:0] rd_q, rd_d;
  logic                         minus_q, minus_d;
  logic                         upper_q, upper_d;
  logic [itoa_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic [itoa_pkg::DigitW-1:0]  dig_buf_q [itoa_pkg::NumDig];

  logic                         in_fire, out_fire;
  logic [28:0]                  quot;
  logic [32:0]                  quot_x10;
  logic [31:0]                  rem_full;
  logic [itoa_pkg::DigitW-1:0]  new_digit;
  logic                         store_digit;
  logic [31:0]                  mag;
  logic                         in_neg;
  logic [itoa_pkg::CountW-1:0]  cnt_next;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // divide by ten through the registered reciprocal product
  assign quot      = prod_q[63:itoa_pkg::RecipSh];
  assign quot_x10  = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign rem_full  = work_q[31:0] - quot_x10[31:0];
  assign new_digit = (state_q == itoa_pkg::ST_HEX) ? work_q[3:0] : rem_full[3:0];
  assign store_digit = (state_q == itoa_pkg::ST_REM) || (state_q == itoa_pkg::ST_HEX);

  assign in_neg = (itoa_pkg::op_e'(in_i.op) == itoa_pkg::OP_SDEC) && in_i.value[31];
  assign mag    = in_neg ? (32'd0 - in_i.value[31:0]) : in_i.value[31:0];

  assign cnt_next = (cnt_q == itoa_pkg::CountMax) ? cnt_q : cnt_q + 31'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.op[1]) begin
            state_d = itoa_pkg::ST_HEX;
          end else begin
            state_d = itoa_pkg::ST_MUL;
          end
        end
      end
      itoa_pkg::ST_MUL: begin
        state_d = itoa_pkg::ST_REM;
      end
      itoa_pkg::ST_REM: begin
        if ((quot != 29'd0) && (nd_q != itoa_pkg::LastIdx)) begin
          state_d = itoa_pkg::ST_MUL;
        end else if (minus_q) begin
          state_d = itoa_pkg::ST_SIGN;
        end else begin
          state_d = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_HEX: begin
        if ((work_q[63:4] != 60'd0) && (nd_q != itoa_pkg::LastIdx)) begin
          state_d = itoa_pkg::ST_HEX;
        end else begin
          state_d = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_o.ready) begin
          state_d = itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_EMIT: begin
        if (out_o.ready && (rd_q == '0)) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // handshake and character outputs
  always_comb begin
    in_i.ready          = 1'b0;
    out_o.valid         = 1'b0;
    out_o.char_code     = itoa_pkg::digit_char(dig_buf_q[rd_q], upper_q);
    out_o.last_char     = 1'b0;
    out_o.total_printed = cnt_next;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      itoa_pkg::ST_SIGN: begin
        out_o.valid     = 1'b1;
        out_o.char_code = itoa_pkg::ChMinus;
      end
      itoa_pkg::ST_EMIT: begin
        out_o.valid     = 1'b1;
        out_o.last_char = (rd_q == '0);
      end
      default: begin
        in_i.ready  = 1'b0;
        out_o.valid = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    work_d  = work_q;
    nd_d    = nd_q;
    rd_d    = rd_q;
    minus_d = minus_q;
    upper_d = upper_q;
    cnt_d   = out_fire ? cnt_next : cnt_q;
    if (in_fire) begin
      nd_d    = '0;
      minus_d = in_neg;
      upper_d = (itoa_pkg::op_e'(in_i.op) == itoa_pkg::OP_HEXU);
      work_d  = in_i.op[1] ? in_i.value : {32'd0, mag};
    end else if (store_digit) begin
      rd_d = nd_q;
      nd_d = nd_q + 4'd1;
      if (state_q == itoa_pkg::ST_HEX) begin
        work_d = {4'd0, work_q[63:4]};
      end else begin
        work_d = {35'd0, quot};
      end
    end else if (out_fire && (state_q == itoa_pkg::ST_EMIT) && (rd_q != '0)) begin
      rd_d = rd_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
      nd_q    <= '0;
      rd_q    <= '0;
      minus_q <= 1'b0;
      upper_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      nd_q    <= nd_d;
      rd_q    <= rd_d;
      minus_q <= minus_d;
      upper_q <= upper_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (state_q == itoa_pkg::ST_MUL) begin
      prod_q <= work_q[31:0] * itoa_pkg::Recip10;
    end
    if (store_digit) begin
      dig_buf_q[nd_q] <= new_digit;
    end
  end

endmodule

`default_nettype wire

[rtl/itoa_checker.sv]
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks for the integer-to-ascii formatter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_last_i,
  input wire logic [itoa_pkg::CountW-1:0] out_total_i
);

  logic in_fire, out_fire;
  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // no new number while characters are pending
  a_busy_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a character is offered");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input ready right after taking a number");

  // more characters follow until the last one
  a_more_after_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_last_i) |=> (out_valid_i && !in_ready_i))
    else $error("character stream ended without last marker");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_last_i) |=> (in_ready_i && !out_valid_i))
    else $error("unit not idle after last character");

  a_total_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(out_total_i))
    else $error("count changed while stalled");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.last_char),
  .out_total_i (out_o.total_printed)
);

`default_nettype wire
